FILE: sv/strided_axis_argmax_assert.svh
// Assertion macros used by the checker module
`ifndef STRIDED_AXIS_ARGMAX_ASSERT_SVH
`define STRIDED_AXIS_ARGMAX_ASSERT_SVH

// Check an implication on every clock edge outside reset
`define SAA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check an implication with the consequent in the following cycle
`define SAA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/saa_pkg.sv
package saa_pkg;
   localparam int DEF_MAX_STRIDE = 1024;
   localparam int DEF_MAX_AXIS = 65536;
   localparam int ELEM_W = 64;
   localparam int INDEX_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_STRIDE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFER_LAST = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_KIND = 2'd3;

   localparam logic [3:0] KIND_BF16 = 4'd8;
   localparam logic [3:0] KIND_FP16 = 4'd9;
   localparam logic [3:0] KIND_FP32 = 4'd10;
   localparam logic [3:0] KIND_FP64 = 4'd11;

   typedef struct packed {
      logic [ELEM_W-1:0] element_bits;
      logic              tensor_start;
   } req_payload_type;

   // Order key: unsigned compare of keys gives element order; nan flags unordered
   typedef struct packed {
      logic [ELEM_W-1:0] key;
      logic              nan;
   } order_key_type;

   function automatic order_key_type make_key(logic [ELEM_W-1:0] v, logic [3:0] kind);
      order_key_type r;
      logic [63:0] m;
      logic        s;
      logic [62:0] mag;
      r.nan = 1'b0;
      m = v;
      s = 1'b0;
      mag = '0;
      case (kind)
         4'd0: m = {{56{v[7]}}, v[7:0]} ^ 64'h8000_0000_0000_0000;
         4'd1: m = {{48{v[15]}}, v[15:0]} ^ 64'h8000_0000_0000_0000;
         4'd2: m = {{32{v[31]}}, v[31:0]} ^ 64'h8000_0000_0000_0000;
         4'd3: m = v ^ 64'h8000_0000_0000_0000;
         4'd4: m = {56'd0, v[7:0]};
         4'd5: m = {48'd0, v[15:0]};
         4'd6: m = {32'd0, v[31:0]};
         KIND_BF16: begin
            s = v[15]; mag = {48'd0, v[14:0]};
            r.nan = (v[14:7] == 8'hFF) && (v[6:0] != 7'd0);
         end
         KIND_FP16: begin
            s = v[15]; mag = {48'd0, v[14:0]};
            r.nan = (v[14:10] == 5'h1F) && (v[9:0] != 10'd0);
         end
         KIND_FP32: begin
            s = v[31]; mag = {32'd0, v[30:0]};
            r.nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
         end
         KIND_FP64: begin
            s = v[63]; mag = v[62:0];
            r.nan = (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
         end
         default: m = v;
      endcase
      // Sign-magnitude floats map to a biased key; both zeros map to the same key
      if (kind >= KIND_BF16 && kind <= KIND_FP64) begin
         if (mag == '0) m = 64'h8000_0000_0000_0000;
         else if (s) m = {1'b0, ~mag} + 64'd1;
         else m = {1'b1, mag};
      end
      r.key = m;
      return r;
   endfunction
endpackage

FILE: sv/saa_stream_if.sv
interface saa_stream_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/strided_axis_argmax.sv
// Streaming argmax along one tensor axis. Elements arrive in memory order on
// req_, one per cycle taken unless a waiting result stalls; each last element
// along the axis yields the axis index of its slice maximum on rsp_ via the
// stage-1 and result registers. Single-port-per-side best-value table (read in
// the accept cycle, written from stage 1; a forwarding path covers back-to-back
// hits). Floats: -0 equals +0; NaN never displaces the best, but a NaN at axis
// index 0 is never displaced. Write csr_ only while idle.
module strided_axis_argmax import saa_pkg::*; #(
   parameter int MAX_STRIDE = DEF_MAX_STRIDE,
   parameter int MAX_AXIS = DEF_MAX_AXIS
) (
   input  logic                  clock,
   input  logic                  reset,
   saa_stream_if.sink            req,
   saa_stream_if.source          rsp,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   localparam int JW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
   localparam int AW = (MAX_AXIS > 1) ? $clog2(MAX_AXIS) : 1;

   logic [16:0] axis_length_ff;
   logic [10:0] inner_stride_ff;
   logic        prefer_last_ff;
   logic [3:0]  element_kind_ff;

   req_payload_type req_p;
   logic accept;
   logic [JW-1:0] j;
   logic [AW-1:0] a;
   logic last;

   // stage 1 registers
   logic          s1_valid_ff;
   logic [JW-1:0] s1_j_ff;
   logic [AW-1:0] s1_a_ff;
   logic          s1_last_ff;
   logic [ELEM_W-1:0] s1_v_ff;
   logic [ELEM_W+INDEX_W-1:0] rd_data;
   logic [ELEM_W-1:0] old_v;
   logic [INDEX_W-1:0] old_p;
   logic          wr_en;
   logic [ELEM_W+INDEX_W-1:0] wr_data;
   logic          fwd_ff;
   logic [ELEM_W+INDEX_W-1:0] fwd_data_ff;
   order_key_type kn, ko;
   logic beat;
   logic [INDEX_W-1:0] new_p;

   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_length_ff <= 17'd1;
         inner_stride_ff <= 11'd1;
         prefer_last_ff <= 1'b0;
         element_kind_ff <= 4'd0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_AXIS_LENGTH: axis_length_ff <= csr_data;
            CSR_INNER_STRIDE: inner_stride_ff <= csr_data[10:0];
            CSR_PREFER_LAST: prefer_last_ff <= csr_data[0];
            CSR_ELEMENT_KIND: element_kind_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Stall only when the result register is full and a result would be dropped
   assign stall = rsp_valid_ff && !rsp.ready && s1_valid_ff && s1_last_ff;
   assign req.ready = !stall;
   assign req_p = req.payload;
   assign accept = req.valid && req.ready;

   saa_counter #(.MAX_STRIDE(MAX_STRIDE), .MAX_AXIS(MAX_AXIS)) u_cnt (
      .clock(clock), .reset(reset), .advance(accept),
      .tensor_start(req_p.tensor_start), .axis_length(axis_length_ff),
      .inner_stride(inner_stride_ff), .inner_pos(j), .axis_pos(a), .last_axis(last)
   );

   saa_table #(.MAX_STRIDE(MAX_STRIDE)) u_tab (
      .clock(clock), .rd_en(!stall), .rd_addr(j), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(s1_j_ff), .wr_data(wr_data)
   );

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (!stall) s1_valid_ff <= accept;
      if (!stall) begin
         s1_j_ff <= j;
         s1_a_ff <= a;
         s1_last_ff <= last;
         s1_v_ff <= req_p.element_bits;
         fwd_ff <= wr_en && (s1_j_ff == j);
         fwd_data_ff <= wr_data;
      end
   end

   // Compare against the stored best, forwarding the entry just written
   always_comb begin
      {old_v, old_p} = fwd_ff ? fwd_data_ff : rd_data;
      kn = make_key(s1_v_ff, element_kind_ff);
      ko = make_key(old_v, element_kind_ff);
      if (kn.nan || ko.nan) beat = 1'b0;
      else beat = prefer_last_ff ? (kn.key >= ko.key) : (kn.key > ko.key);
      new_p = INDEX_W'(s1_a_ff);
      wr_en = s1_valid_ff && !stall && ((s1_a_ff == '0) || beat);
      wr_data = {s1_v_ff, new_p};
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (s1_valid_ff && s1_last_ff && !stall) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
      if (s1_valid_ff && s1_last_ff && !stall)
         rsp_index_ff <= ((s1_a_ff == '0) || beat) ? new_p : old_p;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_index_ff;
endmodule

FILE: sv/saa_counter.sv
module saa_counter import saa_pkg::*; #(
   parameter int MAX_STRIDE = DEF_MAX_STRIDE,
   parameter int MAX_AXIS = DEF_MAX_AXIS,
   localparam int JW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1,
   localparam int AW = (MAX_AXIS > 1) ? $clog2(MAX_AXIS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          tensor_start,
   input  logic [16:0]   axis_length,
   input  logic [10:0]   inner_stride,
   output logic [JW-1:0] inner_pos,
   output logic [AW-1:0] axis_pos,
   output logic          last_axis
);
   logic [JW-1:0] inner_ff, inner_in;
   logic [AW-1:0] axis_ff, axis_in;
   logic [32:0] dim;
   logic [16:0] stride;
   logic [JW-1:0] j;
   logic [AW-1:0] a;

   // Clamp registers into their legal ranges
   always_comb begin
      dim = {16'd0, axis_length};
      if (dim == 33'd0) dim = 33'd1;
      if (dim > 33'(MAX_AXIS)) dim = 33'(MAX_AXIS);
      stride = {6'd0, inner_stride};
      if (stride == 17'd0) stride = 17'd1;
      if ({16'd0, stride} > 33'(MAX_STRIDE)) stride = 17'(MAX_STRIDE);
      j = inner_ff;
      a = axis_ff;
      if (tensor_start) begin
         j = '0; a = '0;
      end
      if (17'(j) >= stride) j = '0;
      if (33'(a) >= dim) a = '0;
      inner_pos = j;
      axis_pos = a;
      last_axis = (33'(a) == dim - 33'd1);
      if (17'(j) + 17'd1 >= stride) begin
         inner_in = '0;
         axis_in = last_axis ? '0 : AW'(a + 1'b1);
      end else begin
         inner_in = JW'(j + 1'b1);
         axis_in = a;
      end
   end

   // Advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= '0;
         axis_ff <= '0;
      end else if (advance) begin
         inner_ff <= inner_in;
         axis_ff <= axis_in;
      end
   end
endmodule

FILE: sv/saa_table.sv
module saa_table import saa_pkg::*; #(
   parameter int MAX_STRIDE = DEF_MAX_STRIDE,
   localparam int JW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [JW-1:0]                  rd_addr,
   output logic [ELEM_W+INDEX_W-1:0]      rd_data,
   input  logic                           wr_en,
   input  logic [JW-1:0]                  wr_addr,
   input  logic [ELEM_W+INDEX_W-1:0]      wr_data
);
   logic [ELEM_W+INDEX_W-1:0] mem [MAX_STRIDE];

   // Write the best entry, register the read; hold the read data while stalled
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule

FILE: sv/saa_checker.sv
module saa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_payload
);
`include "strided_axis_argmax_assert.svh"
   // result held while stalled
   `SAA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   // a stall on input only happens with a waiting result
   `SAA_ASSERT_IMP(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   // nothing appears from an idle input with the pipeline drained
   `SAA_ASSERT_NEXT(a_no_invent, clock, reset, !rsp_valid && !(req_valid && req_ready) && !$past(req_valid && req_ready), !rsp_valid)
endmodule

bind strided_axis_argmax saa_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
